[rtl/nat_port_block_allocator_core_assert.svh]
// Assertion macros for the port block allocator.
`ifndef NAT_PORT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define NAT_PORT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define NPBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nat_pba: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define NPBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nat_pba: next-cycle check failed");

`endif

[rtl/nat_pba_pkg.sv]
// Shared types and constants for the NAT port block allocator.
package nat_pba_pkg;

  localparam int TABLE_DEPTH_DEF        = 1024;
  localparam int BLOCKS_PER_ADDRESS_DEF = 1008;
  localparam logic [15:0] PORT_BASE     = 16'd1024;
  localparam logic [6:0]  DEFAULT_PORTS = 7'd64;
  localparam logic [10:0] LIMIT_RESET   = 11'd1024;
  localparam logic [6:0]  SIZE_RESET    = 7'd64;

  localparam logic [0:0] CFG_BLOCK_LIMIT = 1'b0;
  localparam logic [0:0] CFG_BLOCK_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    FN_RESERVE  = 2'd0,
    FN_ALLOCATE = 2'd1,
    FN_RELEASE  = 2'd2,
    FN_QUERY    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NO_PORT   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_MISS
  } fsm_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] subscriber;
    logic [31:0] public_addr;
    logic [15:0] release_port;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] given_port;
    logic [9:0]  block_index;
    logic [15:0] first_port;
    logic [6:0]  ports_in_block;
    logic [63:0] used_map;
  } out_word_t;

  typedef struct packed {
    logic [31:0] subscriber;
    logic [31:0] address;
    logic [63:0] map;
    logic [6:0]  size;
    logic [15:0] start;
  } entry_t;

  typedef struct packed {
    logic       found;
    logic [5:0] bit_pos;
  } pick_t;

endpackage

[rtl/nat_port_block_allocator_core.sv]
// Top level of the NAT port block allocator: entry table, scan control and result register.
//
//   channel | signals                        | direction
//   in      | in_valid, in_ready, in_data    | request word in
//   out     | out_valid, out_ready, out_data | result word out
//   cfg     | cfg_we, cfg_index, cfg_data    | register write in
//
// A taken request reads the table one entry per cycle; a key hit goes to the
// finishing step, and once the last read has been checked with no hit the miss
// path decides and writes back. Requests are taken only while idle, after each
// result is registered, so a new request waits until the last one is done.
// Reset clears the fill count, so no clearing pass runs after reset.
// A result waiting on out_ready holds the finishing step until the register frees.
module nat_port_block_allocator_core #(
  parameter int TABLE_DEPTH        = nat_pba_pkg::TABLE_DEPTH_DEF,
  parameter int BLOCKS_PER_ADDRESS = nat_pba_pkg::BLOCKS_PER_ADDRESS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  nat_pba_pkg::in_word_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output nat_pba_pkg::out_word_t out_data,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [10:0]            cfg_data
);
  import nat_pba_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int WW = (CW > 11) ? CW : 11;
  localparam int MW = (BLOCKS_PER_ADDRESS > 1) ? $clog2(BLOCKS_PER_ADDRESS) : 1;

  fsm_t            state, state_next;
  in_word_t        req;
  logic [CW-1:0]   cnt;
  logic            pend;
  logic [IW-1:0]   pend_idx;
  logic [IW-1:0]   hit_idx;
  entry_t          hold;
  logic [CW-1:0]   used;
  logic [MW-1:0]   mod_cnt;
  logic [10:0]     limit;
  logic [6:0]      nsize;

  entry_t          mem [TABLE_DEPTH];
  entry_t          rdata;
  logic            mem_re, mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  pick_t           pick;
  logic            key_hit, out_free, full, in_range;
  logic [16:0]     start_ext, end_ext, rport_ext;
  logic [15:0]     offset;
  logic [6:0]      new_size;
  logic [MW+6:0]   prod;
  logic [15:0]     new_start;
  out_word_t       res;
  logic            done;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[cnt[IW-1:0]];
  end

  nat_pba_pick u_pick (.used_map(hold.map), .size(hold.size), .pick(pick));

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign mem_re   = (state == S_SCAN) && (cnt < used);
  assign key_hit  = pend && (rdata.subscriber == req.subscriber) &&
                    (rdata.address == req.public_addr);
  assign full     = (WW'(used) >= WW'(limit)) || (WW'(used) >= WW'(TABLE_DEPTH));

  assign start_ext = {1'b0, hold.start};
  assign end_ext   = start_ext + 17'(hold.size);
  assign rport_ext = {1'b0, req.release_port};
  assign in_range  = (rport_ext >= start_ext) && (rport_ext < end_ext);
  assign offset    = req.release_port - hold.start;

  assign new_size  = (req.func == FN_ALLOCATE) ? DEFAULT_PORTS : nsize;
  assign prod      = mod_cnt * new_size;
  assign new_start = PORT_BASE + 16'(prod);

  always_comb begin
    state_next = state;
    res        = '0;
    done       = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = hit_idx;
    mem_wdata  = hold;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (key_hit) state_next = S_FINISH;
        else if (!mem_re && !pend) state_next = S_MISS;
      end
      S_FINISH: begin
        res.block_index    = 10'(hit_idx);
        res.first_port     = hold.start;
        res.ports_in_block = hold.size;
        res.used_map       = hold.map;
        res.status         = ST_OK;
        case (req.func)
          FN_ALLOCATE: begin
            if (pick.found) begin
              mem_wdata.map = hold.map | (64'd1 << pick.bit_pos);
              res.used_map  = mem_wdata.map;
              res.given_port = hold.start + 16'(pick.bit_pos);
              mem_we = 1'b1;
            end else begin
              res.status = ST_NO_PORT;
            end
          end
          FN_RELEASE: begin
            if (in_range) begin
              if (offset < 16'd64) mem_wdata.map = hold.map & ~(64'd1 << offset[5:0]);
              res.used_map = mem_wdata.map;
              mem_we = 1'b1;
            end else begin
              res = '0;
              res.status = ST_NOT_FOUND;
            end
          end
          default: ;
        endcase
        if (!out_free) mem_we = 1'b0;
        done = out_free;
        if (out_free) state_next = S_IDLE;
      end
      S_MISS: begin
        mem_waddr = used[IW-1:0];
        mem_wdata.subscriber = req.subscriber;
        mem_wdata.address    = req.public_addr;
        mem_wdata.size       = new_size;
        mem_wdata.start      = new_start;
        mem_wdata.map        = (req.func == FN_ALLOCATE) ? 64'd1 : 64'd0;
        if (req.func == FN_RESERVE || req.func == FN_ALLOCATE) begin
          if (full) begin
            res.status = ST_EXHAUSTED;
          end else begin
            mem_we             = out_free;
            res.status         = ST_OK;
            res.block_index    = 10'(used);
            res.first_port     = new_start;
            res.ports_in_block = new_size;
            res.used_map       = mem_wdata.map;
            res.given_port     = (req.func == FN_ALLOCATE) ? new_start : 16'd0;
          end
        end else begin
          res.status = ST_NOT_FOUND;
        end
        done = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pend    <= 1'b0;
      used    <= '0;
      mod_cnt <= '0;
      limit   <= LIMIT_RESET;
      nsize   <= SIZE_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_LIMIT: limit <= cfg_data;
          CFG_BLOCK_SIZE:  nsize <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (state == S_SCAN) pend <= mem_re;
      else pend <= 1'b0;
      // advance the append point and its wrap counter together
      if (mem_we && state == S_MISS) begin
        used    <= used + 1'b1;
        mod_cnt <= (mod_cnt == MW'(BLOCKS_PER_ADDRESS - 1)) ? '0 : mod_cnt + 1'b1;
      end
      if (done) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
      cnt <= '0;
    end else if (mem_re) begin
      cnt <= cnt + 1'b1;
    end
    pend_idx <= cnt[IW-1:0];
    if (state == S_SCAN && key_hit) begin
      hold    <= rdata;
      hit_idx <= pend_idx;
    end
    if (done) out_data <= res;
  end

  `include "nat_port_block_allocator_core_assert.svh"

  `NPBA_ASSERT_NOW(a_used_cap, 1'b1, WW'(used) <= WW'(TABLE_DEPTH))
  `NPBA_ASSERT_NEXT(a_take_starts_scan, in_valid && in_ready, state == S_SCAN)
  `NPBA_ASSERT_NOW(a_write_when_done, mem_we, done)
  `NPBA_ASSERT_NOW(a_read_in_range, mem_re, cnt < used)

endmodule

[rtl/nat_pba_pick.sv]
// Lowest free port finder over one block's used map.
module nat_pba_pick (
  input  logic [63:0]        used_map,
  input  logic [6:0]         size,
  output nat_pba_pkg::pick_t pick
);
  import nat_pba_pkg::*;

  always_comb begin
    pick = '0;
    // scan downward so the lowest free candidate wins
    for (int i = 63; i >= 0; i--) begin
      if ((7'(i) < size) && !used_map[i]) begin
        pick.found   = 1'b1;
        pick.bit_pos = 6'(i);
      end
    end
  end

endmodule
